FILE: rtl/core/bspd_pkg.sv
// Shared types, constants and the CRC step for the byte-stuffed packet deframer.
package bspd_pkg;

  // Link framing bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // CRC-16/X.25, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_XOUT = 16'hFFFF;

  // Largest payload length accepted in the header
  localparam logic [15:0] MAX_PAYLOAD = 16'd256;

  // Frame layout
  localparam logic [8:0] HDR_LEN   = 9'd6;
  localparam logic [8:0] COUNT_MAX = 9'd511;

  // Header byte positions
  localparam logic [2:0] HDR_IDENT  = 3'd0;
  localparam logic [2:0] HDR_OPTS   = 3'd1;
  localparam logic [2:0] HDR_MSG_LO = 3'd2;
  localparam logic [2:0] HDR_MSG_HI = 3'd3;
  localparam logic [2:0] HDR_LEN_LO = 3'd4;
  localparam logic [2:0] HDR_LEN_HI = 3'd5;

  // Result kinds
  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // End-of-frame status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_OVERSIZE = 2'd2,
    ST_SHORT    = 2'd3
  } frame_status_t;

  // One byte through the reflected CRC, bit-serial over eight steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/bspd_if.sv
// Valid/ready channel interfaces for the deframer input bytes and results.
interface bspd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bspd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [7:0]  byte_index;
  logic [7:0]  packet_ident;
  logic [7:0]  option_bits;
  logic [15:0] message_code;
  logic [15:0] payload_length;
  logic [1:0]  frame_status;

  modport source (output valid, output kind, output payload_byte, output byte_index,
                  output packet_ident, output option_bits, output message_code,
                  output payload_length, output frame_status, input ready);
  modport sink   (input valid, input kind, input payload_byte, input byte_index,
                  input packet_ident, input option_bits, input message_code,
                  input payload_length, input frame_status, output ready);
endinterface

FILE: rtl/core/byte_stuffed_packet_deframer_crc16.sv
// Byte-stuffed packet deframer: unescape, header capture, CRC-16 check, payload and status out.
// One raw link byte per transaction on in_ch; results leave on out_ch. The block sustains one
// byte per clock while out_ch takes results: the byte is captured in an input register, decoded
// by combinational logic (unescape, header capture, CRC-16/X.25 byte update) and the result, if
// any, lands in an output register, from which it is presented on out_ch. The input register
// keeps taking bytes while a result waits in the output register; only a stalled result with
// another one behind it holds off in_ch. A flag byte that closes a frame gives one status
// result; payload bytes give one result each if the header length is within MAX_PAYLOAD; all
// other bytes give none.
module byte_stuffed_packet_deframer_crc16 (
  input  logic          clk,
  input  logic          rst_n,
  bspd_in_if.sink       in_ch,
  bspd_out_if.source    out_ch
);

  // Input register
  logic [7:0]  byte_r;
  logic        bvalid_r;

  // Frame state
  logic        in_frame_r,   in_frame_nxt;
  logic        esc_r,        esc_nxt;
  logic [8:0]  count_r,      count_nxt;
  logic [15:0] crc_r,        crc_nxt;
  logic [7:0]  ident_r,      ident_nxt;
  logic [7:0]  opts_r,       opts_nxt;
  logic [15:0] msg_r,        msg_nxt;
  logic [15:0] len_r,        len_nxt;
  logic [15:0] chk_r,        chk_nxt;

  // Result register
  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_byte_r;
  logic [7:0]  out_idx_r;
  logic [7:0]  out_ident_r;
  logic [7:0]  out_opts_r;
  logic [15:0] out_msg_r;
  logic [15:0] out_len_r;
  logic [1:0]  out_stat_r;

  // Decode results
  logic                  res_gen;
  bspd_pkg::kind_t       res_kind;
  logic [7:0]            res_byte;
  logic [7:0]            res_idx;
  bspd_pkg::frame_status_t res_stat;
  logic                  adv;
  logic                  is_flag;
  logic                  take;
  logic [7:0]            d;
  logic [16:0]           end_pos;
  logic [16:0]           p_ext;
  logic [8:0]            p_off;

  // Stage advances unless it would produce a result into a full, stalled output register
  assign adv         = bvalid_r && (!res_gen || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !bvalid_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= 1'b0;
    end else if (in_ch.ready) begin
      bvalid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  // Byte decode and frame state update
  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    ident_nxt    = ident_r;
    opts_nxt     = opts_r;
    msg_nxt      = msg_r;
    len_nxt      = len_r;
    chk_nxt      = chk_r;
    res_gen      = 1'b0;
    res_kind     = bspd_pkg::KIND_DATA;
    res_byte     = 8'h00;
    res_idx      = 8'h00;
    res_stat     = bspd_pkg::ST_OK;
    take         = 1'b0;
    d            = byte_r;
    is_flag      = (byte_r == bspd_pkg::FLAG_BYTE);
    end_pos      = {1'b0, len_r} + 17'(bspd_pkg::HDR_LEN);
    p_ext        = {8'h00, count_r};
    p_off        = count_r - bspd_pkg::HDR_LEN;

    if (is_flag) begin
      if (in_frame_r) begin
        // Closing flag: report and return to idle
        res_gen  = 1'b1;
        res_kind = bspd_pkg::KIND_STATUS;
        if (count_r < bspd_pkg::HDR_LEN) begin
          res_stat = bspd_pkg::ST_SHORT;
        end else if (len_r > bspd_pkg::MAX_PAYLOAD) begin
          res_stat = bspd_pkg::ST_OVERSIZE;
        end else if (p_ext < end_pos + 17'd2) begin
          res_stat = bspd_pkg::ST_SHORT;
        end else if (chk_r == (crc_r ^ bspd_pkg::CRC_XOUT)) begin
          res_stat = bspd_pkg::ST_OK;
        end else begin
          res_stat = bspd_pkg::ST_CRC_ERR;
        end
        in_frame_nxt = 1'b0;
        count_nxt    = '0;
        crc_nxt      = bspd_pkg::CRC_INIT;
        ident_nxt    = '0;
        opts_nxt     = '0;
        msg_nxt      = '0;
        len_nxt      = '0;
        chk_nxt      = '0;
      end
      esc_nxt = 1'b0;
    end else begin
      in_frame_nxt = 1'b1;
      if (esc_r) begin
        esc_nxt = 1'b0;
        d       = byte_r ^ bspd_pkg::ESC_XOR;
        take    = 1'b1;
      end else if (byte_r == bspd_pkg::ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        take = 1'b1;
      end
    end

    // Decoded byte: header, payload or check
    if (take) begin
      if (count_r < bspd_pkg::HDR_LEN) begin
        case (count_r[2:0])
          bspd_pkg::HDR_IDENT:  ident_nxt = d;
          bspd_pkg::HDR_OPTS:   opts_nxt  = d;
          bspd_pkg::HDR_MSG_LO: msg_nxt   = {msg_r[15:8], d};
          bspd_pkg::HDR_MSG_HI: msg_nxt   = {d, msg_r[7:0]};
          bspd_pkg::HDR_LEN_LO: len_nxt   = {len_r[15:8], d};
          default:              len_nxt   = {d, len_r[7:0]};
        endcase
        crc_nxt = bspd_pkg::crc_feed(crc_r, d);
      end else if (len_r <= bspd_pkg::MAX_PAYLOAD) begin
        if (p_ext < end_pos) begin
          crc_nxt  = bspd_pkg::crc_feed(crc_r, d);
          res_gen  = 1'b1;
          res_kind = bspd_pkg::KIND_DATA;
          res_byte = d;
          res_idx  = p_off[7:0];
        end else if (p_ext == end_pos) begin
          chk_nxt = {chk_r[15:8], d};
        end else if (p_ext == end_pos + 17'd1) begin
          chk_nxt = {d, chk_r[7:0]};
        end
      end
      if (count_r < bspd_pkg::COUNT_MAX) begin
        count_nxt = count_r + 9'd1;
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      count_r    <= '0;
      crc_r      <= bspd_pkg::CRC_INIT;
      ident_r    <= '0;
      opts_r     <= '0;
      msg_r      <= '0;
      len_r      <= '0;
      chk_r      <= '0;
    end else if (adv) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      count_r    <= count_nxt;
      crc_r      <= crc_nxt;
      ident_r    <= ident_nxt;
      opts_r     <= opts_nxt;
      msg_r      <= msg_nxt;
      len_r      <= len_nxt;
      chk_r      <= chk_nxt;
    end
  end

  // Result register; header fields shown as held before the frame clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res_gen) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (adv && res_gen) begin
      out_kind_r  <= res_kind;
      out_byte_r  <= res_byte;
      out_idx_r   <= res_idx;
      out_ident_r <= ident_r;
      out_opts_r  <= opts_r;
      out_msg_r   <= msg_r;
      out_len_r   <= len_r;
      out_stat_r  <= res_stat;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_kind_r;
  assign out_ch.payload_byte   = out_byte_r;
  assign out_ch.byte_index     = out_idx_r;
  assign out_ch.packet_ident   = out_ident_r;
  assign out_ch.option_bits    = out_opts_r;
  assign out_ch.message_code   = out_msg_r;
  assign out_ch.payload_length = out_len_r;
  assign out_ch.frame_status   = out_stat_r;

  // Idle between frames means the running state sits at its start values
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (count_r == '0) && (crc_r == bspd_pkg::CRC_INIT))
    else $error("frame state not clean outside a frame");

  // A closing flag leaves the block out of frame with the count cleared
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_flag && in_frame_r |=> !in_frame_r && (count_r == '0) && !esc_r)
    else $error("frame not cleared after closing flag");

  // Any non-flag byte opens a frame
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !is_flag |=> in_frame_r)
    else $error("non-flag byte did not open a frame");

  // Payload results stay inside the announced, accepted length
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == bspd_pkg::KIND_DATA) |->
      ({8'h00, out_idx_r} < out_len_r) && (out_len_r <= bspd_pkg::MAX_PAYLOAD)
      && (out_stat_r == bspd_pkg::ST_OK))
    else $error("payload result outside frame length");

endmodule
